/* hw/rtl/bwau_pkg.sv */
// Shared widths, constants and job types for the black/white alpha unmix block.
package bwau_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHANS   = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};
    localparam logic [CHAN_W-1:0] MIN_DIVISOR = {{(CHAN_W-1){1'b0}}, 1'b1};

    typedef logic [NUM_CHANS-1:0][CHAN_W-1:0] chan_vec_t;

    // One color channel waiting for its division.
    typedef struct packed {
        logic [2*CHAN_W-1:0] num;
        logic                sat;
    } lane_job_t;

    // One classified pixel as it sits in the queue.
    typedef struct packed {
        lane_job_t [NUM_CHANS-1:0] lane;
        logic [CHAN_W-1:0]         divisor;
        logic [CHAN_W-1:0]         coverage;
    } pixel_job_t;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* hw/rtl/bwau_front.sv */
// Front end: accepts pixels, recovers coverage and prepares the division jobs.
module bwau_front
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bwau_pkg::chan_vec_t   black,
    input  bwau_pkg::chan_vec_t   white,
    input  bwau_pkg::queue_status_t status,
    output logic                  push,
    output bwau_pkg::pixel_job_t  job
);

    bwau_pkg::chan_vec_t            cand;
    logic [bwau_pkg::CHAN_W-1:0]    coverage;
    logic [bwau_pkg::CHAN_W-1:0]    divisor;

    assign in_ready = !status.full;
    assign push     = in_valid && !status.full;

    // A channel where white is not brighter than black counts as fully covered.
    always_comb
    begin
        for (int ch = 0; ch < bwau_pkg::NUM_CHANS; ch++)
        begin
            if (white[ch] > black[ch])
            begin
                cand[ch] = bwau_pkg::CHAN_MAX - (white[ch] - black[ch]);
            end
            else
            begin
                cand[ch] = bwau_pkg::CHAN_MAX;
            end
        end
    end

    always_comb
    begin
        coverage = '0;
        for (int ch = 0; ch < bwau_pkg::NUM_CHANS; ch++)
        begin
            if (cand[ch] > coverage)
            begin
                coverage = cand[ch];
            end
        end
    end

    assign divisor = (coverage == '0) ? bwau_pkg::MIN_DIVISOR : coverage;

    // Multiplying by 255 is a shift and a subtract. A quotient of 256 or more
    // shows up as an upper half of the product that reaches the divisor.
    always_comb
    begin
        job.divisor  = divisor;
        job.coverage = coverage;
        for (int ch = 0; ch < bwau_pkg::NUM_CHANS; ch++)
        begin
            job.lane[ch].num = {black[ch], {bwau_pkg::CHAN_W{1'b0}}}
                             - {{bwau_pkg::CHAN_W{1'b0}}, black[ch]};
            job.lane[ch].sat = (job.lane[ch].num[2*bwau_pkg::CHAN_W-1:bwau_pkg::CHAN_W]
                                >= divisor);
        end
    end

endmodule

/* hw/rtl/bwau_fifo.sv */
// Short queue of classified pixels between the front and back ends.
module bwau_fifo
#(
    parameter int DEPTH = bwau_pkg::QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bwau_pkg::pixel_job_t    push_data,
    input  logic                    pop,
    output bwau_pkg::pixel_job_t    pop_data,
    output bwau_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bwau_pkg::pixel_job_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count exceeds depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");
`endif

endmodule

/* hw/rtl/bwau_back.sv */
// Back end: pipelined restoring divider, one quotient bit per stage, three lanes.
module bwau_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  bwau_pkg::queue_status_t status,
    input  bwau_pkg::pixel_job_t    job,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bwau_pkg::chan_vec_t     straight,
    output logic [bwau_pkg::CHAN_W-1:0] coverage
);

    localparam int W      = bwau_pkg::CHAN_W;
    localparam int STAGES = bwau_pkg::CHAN_W;

    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] low;
        logic [W-1:0] quo;
        logic         sat;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [bwau_pkg::NUM_CHANS-1:0] lane;
        logic [W-1:0]                        divisor;
        logic [W-1:0]                        coverage;
    } div_stage_t;

    // One step of restoring division: bring down a dividend bit, subtract if it fits.
    function automatic div_lane_t div_step(div_lane_t l, logic [W-1:0] d);
        div_lane_t r;
        logic [W:0] trial;
        r     = l;
        trial = {l.rem, l.low[W-1]};
        if (trial >= {1'b0, d})
        begin
            trial = trial - {1'b0, d};
            r.quo = {l.quo[W-2:0], 1'b1};
        end
        else
        begin
            r.quo = {l.quo[W-2:0], 1'b0};
        end
        r.rem = trial[W-1:0];
        r.low = {l.low[W-2:0], 1'b0};
        return r;
    endfunction

    div_stage_t stage_reg [STAGES];
    div_stage_t stage_next [STAGES];
    logic [STAGES-1:0] vld_reg, vld_next;
    logic              adv;
    div_stage_t        load;

    // The pipeline moves as a whole unless a finished result is held back.
    assign adv = !vld_reg[STAGES-1] || out_ready;
    assign pop = adv && !status.empty;

    always_comb
    begin
        load.divisor  = job.divisor;
        load.coverage = job.coverage;
        for (int ch = 0; ch < bwau_pkg::NUM_CHANS; ch++)
        begin
            load.lane[ch].rem = job.lane[ch].num[2*W-1:W];
            load.lane[ch].low = job.lane[ch].num[W-1:0];
            load.lane[ch].quo = '0;
            load.lane[ch].sat = job.lane[ch].sat;
        end
    end

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            stage_next[s] = (s == 0) ? load : stage_reg[(s == 0) ? 0 : s - 1];
            for (int ch = 0; ch < bwau_pkg::NUM_CHANS; ch++)
            begin
                stage_next[s].lane[ch] = div_step(stage_next[s].lane[ch],
                                                  stage_next[s].divisor);
            end
        end
        vld_next = {vld_reg[STAGES-2:0], pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign coverage  = stage_reg[STAGES-1].coverage;

    always_comb
    begin
        for (int ch = 0; ch < bwau_pkg::NUM_CHANS; ch++)
        begin
            straight[ch] = stage_reg[STAGES-1].lane[ch].sat ? bwau_pkg::CHAN_MAX
                                                            : stage_reg[STAGES-1].lane[ch].quo;
        end
    end

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(straight)
                                       && $stable(coverage)))
        else $error("stalled result changed");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !pop)
        else $error("queue popped while output stalled");

    a_zero_cov: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && coverage == '0) |-> (straight == '0))
        else $error("zero coverage with nonzero color");
`endif

endmodule

/* hw/rtl/black_white_alpha_unmix.sv */
// Top level of the black/white alpha unmix block.
//
// Each input transaction carries one pixel rendered over black and over white
// (three 8-bit channels each); each output transaction carries the recovered
// straight color channels and the coverage used as alpha. Both channels use
// valid/ready, and a transaction completes when both are high at a clock edge.
//
// The front end computes coverage and the scaled dividends in the accepting
// cycle and writes them to a short queue. The back end is an eight-stage
// divider, one quotient bit per stage for all three channels in parallel.
// Throughput is one pixel per clock while out_ready stays high. A result passes
// from the queue through the divider stages to out_valid.
//
// If the receiver holds out_ready low, the divider pipeline freezes once a
// result reaches its last stage and holds it; the front end keeps accepting
// until the queue (QUEUE_DEPTH entries) is full, then drops in_ready. Reset
// empties the queue and the pipeline; no pixel state survives it.
module black_white_alpha_unmix
#(
    parameter int QUEUE_DEPTH = bwau_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] black_ch0,
    input  logic [7:0] black_ch1,
    input  logic [7:0] black_ch2,
    input  logic [7:0] white_ch0,
    input  logic [7:0] white_ch1,
    input  logic [7:0] white_ch2,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] straight_ch0,
    output logic [7:0] straight_ch1,
    output logic [7:0] straight_ch2,
    output logic [7:0] coverage_alpha
);

    bwau_pkg::chan_vec_t     black;
    bwau_pkg::chan_vec_t     white;
    bwau_pkg::chan_vec_t     straight;
    bwau_pkg::pixel_job_t    push_job;
    bwau_pkg::pixel_job_t    head_job;
    bwau_pkg::queue_status_t status;
    logic                    push;
    logic                    pop;

    assign black = {black_ch2, black_ch1, black_ch0};
    assign white = {white_ch2, white_ch1, white_ch0};

    bwau_front u_front
    (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .black    (black),
        .white    (white),
        .status   (status),
        .push     (push),
        .job      (push_job)
    );

    bwau_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (head_job),
        .status    (status)
    );

    bwau_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .job       (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .straight  (straight),
        .coverage  (coverage_alpha)
    );

    assign straight_ch0 = straight[0];
    assign straight_ch1 = straight[1];
    assign straight_ch2 = straight[2];

endmodule
